>>> rtl/cbz_pkg.sv
// shared constants, register codes and beat types of the cubic bezier segment generator
`default_nettype none

package cbz_pkg;

	// coordinate and field widths
	localparam int COORD_BITS  = 12;
	localparam int CURVE_BITS  = 8;
	localparam int SEG_CNT_BITS = 7;

	// defaults for the top level parameters
	localparam int MAX_SEGMENTS = 64;
	localparam int T_FRAC_BITS  = 16;

	// register reset values
	localparam logic [SEG_CNT_BITS-1:0] SEG_COUNT_RESET = 7'd50;

	// register select codes, taken from paddr[2]
	localparam logic REG_SEGMENT_COUNT = 1'b0;
	localparam logic REG_TANGENT_MODE  = 1'b1;

	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	typedef struct packed {
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic                  final_point;
	} point_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
		logic [CURVE_BITS-1:0] curve_number;
		logic                  run_end;
	} seg_t;

endpackage

`default_nettype wire

>>> rtl/cubic_bezier_segment_gen.sv
// top level of the cubic bezier segment generator: sequencer, shared multiplier, apb registers
`default_nettype none

// Control points come in one beat each; every fourth point (counting joints once) closes a
// cubic curve, which is then cut into N = segment_count line segments at t = j/N and sent out
// one segment per beat, in order of t, tagged with the curve index and run_end on the last
// one. A point that does not close a curve is taken while the block stays idle. A point that
// closes a curve holds point_ready low while the curve is produced, longer when the output
// stalls: the divider forms 2^F / N, a setup step follows, then every segment is evaluated,
// the last one included (its evaluated point is replaced by the curve end point); a
// single-segment curve skips the evaluation. The single multiplier forms the 14 products of
// each segment one per cycle and then drains its pipe; the division uses a one-bit-per-cycle
// restoring loop. With tangent_mode set, an interior joint waits for the next point and is
// replaced by the floor average of its neighbours, so a curve is released one point later.
// Registers: segment_count at address 0 (0 acts as 1, values above MAX_SEGMENTS clamp),
// tangent_mode at address 4; write them only while the block is idle.
module cubic_bezier_segment_gen #(
	parameter int MAX_SEGMENTS = cbz_pkg::MAX_SEGMENTS,
	parameter int T_FRAC_BITS  = cbz_pkg::T_FRAC_BITS
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// control point channel
	input  wire                                 point_valid,
	output logic                                point_ready,
	input  cbz_pkg::point_t                     point,
	// segment channel
	output logic                                seg_valid,
	input  wire                                 seg_ready,
	output cbz_pkg::seg_t                       seg,
	// apb register port
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [cbz_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  wire  [cbz_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [cbz_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                pready
);

	localparam int CW   = cbz_pkg::COORD_BITS;
	localparam int F    = T_FRAC_BITS;
	localparam int NW   = $clog2(MAX_SEGMENTS + 1);       // segment count / index width
	localparam int TW   = F + 1;                          // t, u and the plain weights
	localparam int WW   = F + 2;                          // weights scaled by three
	localparam int OPW  = (WW > CW) ? WW : CW;            // multiplier operand width
	localparam int PW   = 2 * OPW;                        // product width
	localparam int TERM = CW + F + 2;                     // width of one coordinate term
	localparam int ACCW = CW + F + 4;                     // four terms summed
	localparam int DCW  = $clog2(F + 1);
	localparam int SCW  = cbz_pkg::SEG_CNT_BITS;
	localparam logic [TW-1:0] ONE = TW'(1) << F;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_INIT,
		S_EVAL,
		S_EMIT
	} state_t;

	// one step per multiplier slot; the last two only drain the product pipe
	typedef enum logic [3:0] {
		OP_UU, OP_TT, OP_W0, OP_W1, OP_W2, OP_W3,
		OP_X0, OP_X1, OP_X2, OP_X3,
		OP_Y0, OP_Y1, OP_Y2, OP_Y3,
		OP_WAIT, OP_DONE
	} op_t;

	// number of points of the current curve held so far, its start point included
	typedef enum logic [1:0] {
		PH_EMPTY, PH_ONE, PH_TWO, PH_THREE
	} phase_t;

	// control state
	state_t                state_q;
	op_t                   step_q;
	op_t                   wop_q;
	logic                  wval_q;
	logic [DCW-1:0]        dcnt_q;
	logic [NW-1:0]         j_q;
	phase_t                phase_q;
	logic [cbz_pkg::CURVE_BITS-1:0] cc_q;
	logic                  pend_q;
	logic                  post_pend_q;
	logic                  fin_q;
	logic                  seg_valid_q;
	logic [SCW-1:0]        seg_count_q;
	logic                  tm_q;

	// point window and hold point
	logic [CW-1:0]         p0x_q, p0y_q, p1x_q, p1y_q, p2x_q, p2y_q, p3x_q, p3y_q;
	logic [CW-1:0]         hx_q, hy_q;

	// datapath
	logic [TW-1:0]         q0_q;
	logic [NW-1:0]         r0_q;
	logic [TW-1:0]         t_q, u_q;
	logic [NW-1:0]         rem_q;
	logic [TW-1:0]         su_q, st_q, w0_q, w3_q;
	logic [WW-1:0]         w1_q, w2_q;
	logic [PW-1:0]         mul_q;
	logic [ACCW-1:0]       acc_q;
	logic [CW-1:0]         nx_q, ny_q, sx_q, sy_q;
	cbz_pkg::seg_t         seg_q;

	// combinational
	logic                  in_acc;
	logic                  go_emit;
	logic                  cfg_wr;
	logic                  load;
	logic                  last;
	logic [NW-1:0]         n_w;
	logic [NW:0]           div_sh;
	logic                  div_ge;
	logic [NW:0]           rsum;
	logic                  carry;
	logic [OPW-1:0]        mul_a, mul_b;
	logic [PW-1:0]         mul_w;
	logic [PW-1:0]         mul_sh;
	logic [TW-1:0]         mul_t;
	logic [ACCW-F-1:0]     acc_sh;
	logic [CW-1:0]         sat;
	logic [CW:0]           mid_x, mid_y;
	logic [CW-1:0]         end_x, end_y;

	assign point_ready = (state_q == S_IDLE);
	assign seg_valid   = seg_valid_q;
	assign seg         = seg_q;
	assign pready      = 1'b1;

	assign in_acc  = point_valid && point_ready;
	assign cfg_wr  = psel && penable && pwrite;
	// a pending joint always closes its curve; a fourth point closes it unless it must wait
	assign go_emit = pend_q || ((phase_q == PH_THREE) && (point.final_point || !tm_q));
	assign load    = (state_q == S_EMIT) && (!seg_valid_q || seg_ready);
	assign last    = (j_q == n_w);

	// clamp the segment count into 1..MAX_SEGMENTS
	always_comb begin
		if (seg_count_q == '0) begin
			n_w = NW'(1);
		end else if (seg_count_q > SCW'(MAX_SEGMENTS)) begin
			n_w = NW'(MAX_SEGMENTS);
		end else begin
			n_w = seg_count_q[NW-1:0];
		end
	end

	// restoring division of 2^F by n, one quotient bit per cycle
	assign div_sh = {r0_q, (dcnt_q == '0)};
	assign div_ge = (div_sh >= {1'b0, n_w});

	// t advance: t(j+1) = t(j) + q0 + carry out of the remainder
	assign rsum  = {1'b0, rem_q} + {1'b0, r0_q};
	assign carry = (rsum >= {1'b0, n_w});

	// midpoint of p2 and the incoming point for a pending joint
	assign mid_x = {1'b0, p2x_q} + {1'b0, point.px};
	assign mid_y = {1'b0, p2y_q} + {1'b0, point.py};

	// operand select for the shared multiplier
	always_comb begin
		unique case (step_q)
			OP_UU: begin mul_a = OPW'(u_q);   mul_b = OPW'(u_q);  end
			OP_TT: begin mul_a = OPW'(t_q);   mul_b = OPW'(t_q);  end
			OP_W0: begin mul_a = OPW'(su_q);  mul_b = OPW'(u_q);  end
			OP_W1: begin mul_a = OPW'(t_q);   mul_b = OPW'(su_q); end
			OP_W2: begin mul_a = OPW'(st_q);  mul_b = OPW'(u_q);  end
			OP_W3: begin mul_a = OPW'(st_q);  mul_b = OPW'(t_q);  end
			OP_X0: begin mul_a = OPW'(p0x_q); mul_b = OPW'(w0_q); end
			OP_X1: begin mul_a = OPW'(p1x_q); mul_b = OPW'(w1_q); end
			OP_X2: begin mul_a = OPW'(p2x_q); mul_b = OPW'(w2_q); end
			OP_X3: begin mul_a = OPW'(p3x_q); mul_b = OPW'(w3_q); end
			OP_Y0: begin mul_a = OPW'(p0y_q); mul_b = OPW'(w0_q); end
			OP_Y1: begin mul_a = OPW'(p1y_q); mul_b = OPW'(w1_q); end
			OP_Y2: begin mul_a = OPW'(p2y_q); mul_b = OPW'(w2_q); end
			OP_Y3: begin mul_a = OPW'(p3y_q); mul_b = OPW'(w3_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_w  = mul_a * mul_b;
	assign mul_sh = mul_q >> F;
	assign mul_t  = mul_sh[TW-1:0];

	// scale the sum back and saturate to the coordinate range
	assign acc_sh = acc_q[ACCW-1:F];
	assign sat    = (|acc_sh[ACCW-F-1:CW]) ? {CW{1'b1}} : acc_sh[CW-1:0];

	// last segment ends exactly on the curve end point
	assign end_x = last ? p3x_q : nx_q;
	assign end_y = last ? p3y_q : ny_q;

	// register read
	always_comb begin
		unique case (paddr[2])
			cbz_pkg::REG_SEGMENT_COUNT: prdata = cbz_pkg::APB_DATA_BITS'(seg_count_q);
			cbz_pkg::REG_TANGENT_MODE:  prdata = cbz_pkg::APB_DATA_BITS'(tm_q);
		endcase
	end

	// sequencer, chain state, registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= OP_UU;
			wop_q       <= OP_UU;
			wval_q      <= 1'b0;
			dcnt_q      <= '0;
			j_q         <= '0;
			phase_q     <= PH_EMPTY;
			cc_q        <= '0;
			pend_q      <= 1'b0;
			post_pend_q <= 1'b0;
			fin_q       <= 1'b0;
			seg_valid_q <= 1'b0;
			seg_count_q <= cbz_pkg::SEG_COUNT_RESET;
			tm_q        <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[2])
					cbz_pkg::REG_SEGMENT_COUNT: seg_count_q <= pwdata[SCW-1:0];
					cbz_pkg::REG_TANGENT_MODE:  tm_q        <= pwdata[0];
				endcase
			end

			wval_q <= (state_q == S_EVAL) && (step_q != OP_WAIT) && (step_q != OP_DONE);
			wop_q  <= step_q;

			if (load) begin
				seg_valid_q <= 1'b1;
			end else if (seg_ready) begin
				seg_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						fin_q       <= point.final_point;
						post_pend_q <= pend_q;
						if (go_emit) begin
							state_q <= S_DIV;
							dcnt_q  <= '0;
						end else if (point.final_point) begin
							// chain ends without a complete curve
							phase_q <= PH_EMPTY;
							cc_q    <= '0;
							pend_q  <= 1'b0;
						end else if (phase_q != PH_THREE) begin
							phase_q <= phase_t'(phase_q + 2'd1);
						end else begin
							pend_q <= 1'b1;
						end
					end
				end
				S_DIV: begin
					if (dcnt_q == DCW'(F)) begin
						state_q <= S_INIT;
					end else begin
						dcnt_q <= dcnt_q + DCW'(1);
					end
				end
				S_INIT: begin
					j_q    <= NW'(1);
					step_q <= OP_UU;
					if (n_w == NW'(1)) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (step_q == OP_DONE) begin
						state_q <= S_EMIT;
					end else begin
						step_q <= op_t'(step_q + 4'd1);
					end
				end
				S_EMIT: begin
					if (load) begin
						if (last) begin
							state_q <= S_IDLE;
							pend_q  <= 1'b0;
							// a final point ends the chain
							if (fin_q) begin
								phase_q <= PH_EMPTY;
								cc_q    <= '0;
							end else begin
								phase_q <= post_pend_q ? PH_TWO : PH_ONE;
								cc_q    <= cc_q + 8'd1;
							end
						end else begin
							j_q     <= j_q + NW'(1);
							step_q  <= OP_UU;
							state_q <= S_EVAL;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// point window, divider, t stepping, multiplier pipe and output beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (pend_q) begin
				p3x_q <= mid_x[CW:1];
				p3y_q <= mid_y[CW:1];
				hx_q  <= point.px;
				hy_q  <= point.py;
			end else begin
				unique case (phase_q)
					PH_EMPTY: begin p0x_q <= point.px; p0y_q <= point.py; end
					PH_ONE:   begin p1x_q <= point.px; p1y_q <= point.py; end
					PH_TWO:   begin p2x_q <= point.px; p2y_q <= point.py; end
					PH_THREE: begin p3x_q <= point.px; p3y_q <= point.py; end
				endcase
			end
			q0_q <= '0;
			r0_q <= '0;
		end

		if (state_q == S_DIV) begin
			q0_q <= {q0_q[TW-2:0], div_ge};
			r0_q <= div_ge ? NW'(div_sh - {1'b0, n_w}) : div_sh[NW-1:0];
		end

		if (state_q == S_INIT) begin
			t_q   <= q0_q;
			u_q   <= ONE - q0_q;
			rem_q <= r0_q;
			sx_q  <= p0x_q;
			sy_q  <= p0y_q;
		end

		mul_q <= mul_w;
		if (wval_q) begin
			unique case (wop_q)
				OP_UU: su_q <= mul_t;
				OP_TT: st_q <= mul_t;
				OP_W0: w0_q <= mul_t;
				OP_W1: w1_q <= {1'b0, mul_t} + {mul_t, 1'b0};
				OP_W2: w2_q <= {1'b0, mul_t} + {mul_t, 1'b0};
				OP_W3: w3_q <= mul_t;
				OP_X0: acc_q <= ACCW'(mul_q[TERM-1:0]);
				OP_Y0: begin
					nx_q  <= sat;
					acc_q <= ACCW'(mul_q[TERM-1:0]);
				end
				default: acc_q <= acc_q + ACCW'(mul_q[TERM-1:0]);
			endcase
		end
		if ((state_q == S_EVAL) && (step_q == OP_DONE)) begin
			ny_q <= sat;
		end

		if (load) begin
			seg_q.start_x      <= sx_q;
			seg_q.start_y      <= sy_q;
			seg_q.end_x        <= end_x;
			seg_q.end_y        <= end_y;
			seg_q.curve_number <= cc_q;
			seg_q.run_end      <= last;
			sx_q               <= end_x;
			sy_q               <= end_y;
			rem_q              <= carry ? NW'(rsum - {1'b0, n_w}) : rsum[NW-1:0];
			t_q                <= t_q + q0_q + TW'(carry);
			u_q                <= u_q - q0_q - TW'(carry);
			if (last) begin
				p0x_q <= p3x_q;
				p0y_q <= p3y_q;
				if (post_pend_q) begin
					p1x_q <= hx_q;
					p1y_q <= hy_q;
				end
			end
		end
	end

	// divider leaves q0 * n + r0 == 2^F with r0 below n
	a_div_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |->
			((int'(q0_q) * int'(n_w) + int'(r0_q)) == (1 << F)) && (r0_q < n_w))
		else $error("segment step division is wrong");

	// t and u stay complementary when a segment evaluation starts
	a_tu_sum: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EVAL) && (step_q == OP_UU)) |-> ((t_q + u_q) == ONE))
		else $error("t and u out of step");

	// a joint can only be pending once a full curve is held
	a_pend_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (phase_q == PH_THREE))
		else $error("pending joint without a full curve");

	// the last segment of a curve lands exactly on its end point
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last) |=>
			(seg_q.run_end && (seg_q.end_x == $past(p3x_q)) && (seg_q.end_y == $past(p3y_q))))
		else $error("last segment misses the curve end point");

endmodule

`default_nettype wire
